/* rtl/pclip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pclip_pkg;

   localparam int unsigned DEF_MAX_SUBJECT_VERTS = 16;
   localparam int unsigned DEF_MAX_CLIP_EDGES    = 16;
   localparam int unsigned DEF_WORK_DEPTH        = 32;
   localparam int unsigned DEF_COORD_BITS        = 18;

   typedef enum logic [1:0] {
      ACT_LOAD_VERT = 2'd0,
      ACT_LOAD_EDGE = 2'd1,
      ACT_RUN       = 2'd2
   } action_type;

   // source of the word written into a vertex buffer
   typedef enum logic [1:0] {
      WR_REQ   = 2'd0,
      WR_CROSS = 2'd1,
      WR_CUR   = 2'd2
   } wr_src_type;

   typedef struct packed {
      logic       wr_vert;
      logic       wr_bank;
      wr_src_type wr_src;
      logic       wr_edge;
      logic       rd_vert;
      logic       rd_bank;
      logic       rd_edge;
      logic       mul;
      logic       side_prev;
      logic       side_cur;
      logic       shift_prev;
      logic       div_start;
      logic       div_fin;
      logic       out_load;
      logic       out_empty;
      logic       out_last;
      logic       out_ovf;
   } cmd_type;

   typedef struct packed {
      logic cur_in;
      logic prev_in;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

/* rtl/pclip_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module pclip_datapath import pclip_pkg::*; #(
   parameter int unsigned WORK_DEPTH     = DEF_WORK_DEPTH,
   parameter int unsigned MAX_CLIP_EDGES = DEF_MAX_CLIP_EDGES,
   parameter int unsigned COORD_BITS     = DEF_COORD_BITS,
   parameter int unsigned AW             = $clog2(DEF_WORK_DEPTH),
   parameter int unsigned EAW            = $clog2(DEF_MAX_CLIP_EDGES)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cmd_type                      cmd,
   input  wire logic [AW-1:0]                rd_addr,
   input  wire logic [AW-1:0]                wr_addr,
   input  wire logic [EAW-1:0]               edge_addr,
   input  wire logic signed [COORD_BITS-1:0] req_vert_x,
   input  wire logic signed [COORD_BITS-1:0] req_vert_y,
   input  wire logic signed [COORD_BITS-1:0] req_edge_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_edge_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_edge_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_edge_end_y,
   output status_type                        status,
   output logic signed [COORD_BITS-1:0]      rsp_out_x,
   output logic signed [COORD_BITS-1:0]      rsp_out_y,
   output logic                              rsp_last_vertex,
   output logic                              rsp_empty_result,
   output logic                              rsp_overflow
);

   localparam int unsigned CB  = COORD_BITS;
   localparam int unsigned DW  = CB + 1;
   localparam int unsigned QW  = CB + 1;
   localparam int unsigned PW  = 2 * CB + 2;
   localparam int unsigned SW  = 2 * CB + 3;
   localparam int unsigned SXW = CB + 3;
   localparam int unsigned CW  = $clog2(CB + 2);

   // vertex buffers and edge store
   logic [2*CB-1:0] buf_a [WORK_DEPTH];
   logic [2*CB-1:0] buf_b [WORK_DEPTH];
   logic [4*CB-1:0] edge_mem [MAX_CLIP_EDGES];
   logic [2*CB-1:0] rd_a_ff, rd_b_ff;
   logic [4*CB-1:0] edge_rd_ff;
   logic [2*CB-1:0] wdata;
   logic [2*CB-1:0] vert_rd;
   logic [2*CB-1:0] pt_ff, prev_pt_ff, cur_pt_ff, cross_pt_ff;

   always_comb begin
      case (cmd.wr_src)
         WR_REQ:   wdata = {req_vert_x, req_vert_y};
         WR_CROSS: wdata = cross_pt_ff;
         WR_CUR:   wdata = cur_pt_ff;
         default:  wdata = {req_vert_x, req_vert_y};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_vert && !cmd.wr_bank) begin
         buf_a[wr_addr] <= wdata;
      end
      if (cmd.wr_vert && cmd.wr_bank) begin
         buf_b[wr_addr] <= wdata;
      end
      if (cmd.rd_vert) begin
         rd_a_ff <= buf_a[rd_addr];
         rd_b_ff <= buf_b[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_edge) begin
         edge_mem[edge_addr] <= {req_edge_start_x, req_edge_start_y,
                                 req_edge_end_x, req_edge_end_y};
      end
      if (cmd.rd_edge) begin
         edge_rd_ff <= edge_mem[edge_addr];
      end
   end

   assign vert_rd = cmd.rd_bank ? rd_b_ff : rd_a_ff;

   // side value: (P-u) . (vy-uy, ux-vx)
   logic signed [CB-1:0] pt_x, pt_y, ux, uy, vx, vy;
   logic signed [DW-1:0] dxp, dyp, ey, ex;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic signed [SW-1:0] side_sum;
   logic [63:0]          side64;
   logic [63:0]          dp_ff, dc_ff;

   assign pt_x = $signed(vert_rd[2*CB-1:CB]);
   assign pt_y = $signed(vert_rd[CB-1:0]);
   assign ux   = $signed(edge_rd_ff[4*CB-1:3*CB]);
   assign uy   = $signed(edge_rd_ff[3*CB-1:2*CB]);
   assign vx   = $signed(edge_rd_ff[2*CB-1:CB]);
   assign vy   = $signed(edge_rd_ff[CB-1:0]);
   assign dxp  = DW'(pt_x) - DW'(ux);
   assign dyp  = DW'(pt_y) - DW'(uy);
   assign ey   = DW'(vy) - DW'(uy);
   assign ex   = DW'(ux) - DW'(vx);
   assign side_sum = SW'(p1_ff) + SW'(p2_ff);
   assign side64   = $unsigned(64'(side_sum));

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         p1_ff <= PW'(dxp) * PW'(ey);
         p2_ff <= PW'(dyp) * PW'(ex);
         pt_ff <= vert_rd;
      end
      if (cmd.side_prev) begin
         dp_ff      <= side64;
         prev_pt_ff <= pt_ff;
      end else if (cmd.shift_prev) begin
         dp_ff      <= dc_ff;
         prev_pt_ff <= cur_pt_ff;
      end
      if (cmd.side_cur) begin
         dc_ff     <= side64;
         cur_pt_ff <= pt_ff;
      end
   end

   assign status.cur_in  = dc_ff[63] || (dc_ff == 64'd0);
   assign status.prev_in = dp_ff[63] || (dp_ff == 64'd0);

   // crossing point: prev + (cur-prev)*|dp|/|dp-dc|, one quotient bit per cycle
   logic signed [CB-1:0] prev_x, prev_y, cur_x, cur_y;
   logic signed [DW-1:0] diff_x, diff_y;
   logic [63:0]          den, an, aq;
   logic [63:0]          an_ff, aq_ff;
   logic [QW-1:0]        adx_ff, ady_ff, shx_ff, shy_ff, qx_ff, qy_ff;
   logic [65:0]          rx_ff, ry_ff;
   logic                 negx_ff, negy_ff, zero_ff, full_ff;
   logic [CW-1:0]        cnt_ff;
   logic [67:0]          stx, sty;

   assign prev_x = $signed(prev_pt_ff[2*CB-1:CB]);
   assign prev_y = $signed(prev_pt_ff[CB-1:0]);
   assign cur_x  = $signed(cur_pt_ff[2*CB-1:CB]);
   assign cur_y  = $signed(cur_pt_ff[CB-1:0]);
   assign diff_x = DW'(cur_x) - DW'(prev_x);
   assign diff_y = DW'(cur_y) - DW'(prev_y);
   assign den    = dp_ff - dc_ff;
   assign an     = dp_ff[63] ? 64'd0 - dp_ff : dp_ff;
   assign aq     = den[63] ? 64'd0 - den : den;

   function automatic logic [67:0] div_step(input logic [65:0] r, input logic b,
                                            input logic [63:0] a_n, input logic [63:0] a_q);
      logic [65:0] t, a1, a2;
      t  = {r[64:0], 1'b0} + (b ? {2'b00, a_n} : 66'd0);
      a1 = {2'b00, a_q};
      a2 = {1'b0, a_q, 1'b0};
      if (t >= a2) begin
         div_step = {2'd2, t - a2};
      end else if (t >= a1) begin
         div_step = {2'd1, t - a1};
      end else begin
         div_step = {2'd0, t};
      end
   endfunction

   assign stx = div_step(rx_ff, shx_ff[QW-1], an_ff, aq_ff);
   assign sty = div_step(ry_ff, shy_ff[QW-1], an_ff, aq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff <= CW'(QW);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         an_ff   <= an;
         aq_ff   <= aq;
         zero_ff <= (aq == 64'd0);
         full_ff <= (an >= aq);
         negx_ff <= diff_x[DW-1];
         negy_ff <= diff_y[DW-1];
         adx_ff  <= diff_x[DW-1] ? $unsigned(-diff_x) : $unsigned(diff_x);
         ady_ff  <= diff_y[DW-1] ? $unsigned(-diff_y) : $unsigned(diff_y);
         shx_ff  <= diff_x[DW-1] ? $unsigned(-diff_x) : $unsigned(diff_x);
         shy_ff  <= diff_y[DW-1] ? $unsigned(-diff_y) : $unsigned(diff_y);
         rx_ff   <= '0;
         ry_ff   <= '0;
         qx_ff   <= '0;
         qy_ff   <= '0;
      end else if (cnt_ff != '0) begin
         rx_ff  <= stx[65:0];
         ry_ff  <= sty[65:0];
         qx_ff  <= {qx_ff[QW-2:0], 1'b0} + QW'(stx[67:66]);
         qy_ff  <= {qy_ff[QW-2:0], 1'b0} + QW'(sty[67:66]);
         shx_ff <= {shx_ff[QW-2:0], 1'b0};
         shy_ff <= {shy_ff[QW-2:0], 1'b0};
      end
   end

   assign status.div_done = (cnt_ff == '0);

   function automatic logic [CB-1:0] sat(input logic signed [SXW-1:0] s);
      logic [SXW-CB:0] top;
      top = s[SXW-1:CB-1];
      if (top == '0 || &top) begin
         sat = s[CB-1:0];
      end else if (s[SXW-1]) begin
         sat = {1'b1, {(CB-1){1'b0}}};
      end else begin
         sat = {1'b0, {(CB-1){1'b1}}};
      end
   endfunction

   logic [QW-1:0]         qsel_x, qsel_y;
   logic signed [SXW-1:0] qs_x, qs_y, sum_x, sum_y;

   assign qsel_x = zero_ff ? '0 : (full_ff ? adx_ff : qx_ff);
   assign qsel_y = zero_ff ? '0 : (full_ff ? ady_ff : qy_ff);
   assign qs_x   = $signed({2'b00, qsel_x});
   assign qs_y   = $signed({2'b00, qsel_y});
   assign sum_x  = SXW'(prev_x) + (negx_ff ? -qs_x : qs_x);
   assign sum_y  = SXW'(prev_y) + (negy_ff ? -qs_y : qs_y);

   always_ff @(posedge clock) begin
      if (cmd.div_fin) begin
         cross_pt_ff <= {sat(sum_x), sat(sum_y)};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_out_x        <= cmd.out_empty ? '0 : pt_x;
         rsp_out_y        <= cmd.out_empty ? '0 : pt_y;
         rsp_last_vertex  <= cmd.out_last;
         rsp_empty_result <= cmd.out_empty;
         rsp_overflow     <= cmd.out_ovf;
      end
   end

endmodule

`default_nettype wire

/* rtl/pclip_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pclip_ctrl import pclip_pkg::*; #(
   parameter int unsigned MAX_SUBJECT_VERTS = DEF_MAX_SUBJECT_VERTS,
   parameter int unsigned MAX_CLIP_EDGES    = DEF_MAX_CLIP_EDGES,
   parameter int unsigned WORK_DEPTH        = DEF_WORK_DEPTH,
   parameter int unsigned AW                = $clog2(DEF_WORK_DEPTH),
   parameter int unsigned EAW               = $clog2(DEF_MAX_CLIP_EDGES)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic [1:0]     req_action,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output cmd_type             cmd,
   output logic [AW-1:0]       rd_addr,
   output logic [AW-1:0]       wr_addr,
   output logic [EAW-1:0]      edge_addr,
   input  wire status_type     status
);

   localparam int unsigned SUBJ_CAP =
      (MAX_SUBJECT_VERTS < WORK_DEPTH) ? MAX_SUBJECT_VERTS : WORK_DEPTH;
   localparam int unsigned VCW = $clog2(SUBJ_CAP + 1);
   localparam int unsigned NW  = $clog2(WORK_DEPTH + 1);
   localparam int unsigned ECW = $clog2(MAX_CLIP_EDGES + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_EDGE_RD, S_PREV_MUL, S_PREV_SIDE, S_CUR_RD, S_CUR_MUL, S_CUR_SIDE,
      S_DECIDE, S_DIV, S_DIV_FIN, S_PUSH_X, S_PUSH_CUR, S_NEXT, S_PASS_END,
      S_EMIT_CHK, S_EMIT_RD, S_EMIT_LOAD, S_EMIT_HOLD
   } state_type;

   state_type      state_ff, state_in;
   logic           bank_ff, bank_in;
   logic [VCW-1:0] vcount_ff, vcount_in;
   logic [ECW-1:0] ecount_ff, ecount_in;
   logic [ECW-1:0] k_ff, k_in, k_next;
   logic           ovf_ff, ovf_in;
   logic [NW-1:0]  n_ff, n_in, m_ff, m_in, i_ff, i_in, j_ff, j_in;
   logic [NW-1:0]  vcount_n, n_last, i_next, j_next;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign vcount_n = NW'(vcount_ff);
   assign n_last   = n_ff - 1'b1;
   assign i_next   = i_ff + 1'b1;
   assign j_next   = j_ff + 1'b1;
   assign k_next   = k_ff + 1'b1;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      vcount_in    = vcount_ff;
      ecount_in    = ecount_ff;
      k_in         = k_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.rd_bank  = bank_ff;
      cmd.wr_bank  = ~bank_ff;
      cmd.out_ovf  = ovf_ff;
      rd_addr      = '0;
      wr_addr      = m_ff[AW-1:0];
      edge_addr    = k_ff[EAW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (action_type'(req_action))
                  ACT_LOAD_VERT: begin
                     if (vcount_ff < VCW'(SUBJ_CAP)) begin
                        cmd.wr_vert = 1'b1;
                        cmd.wr_bank = 1'b0;
                        cmd.wr_src  = WR_REQ;
                        wr_addr     = vcount_n[AW-1:0];
                        vcount_in   = vcount_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ACT_LOAD_EDGE: begin
                     if (ecount_ff < ECW'(MAX_CLIP_EDGES)) begin
                        cmd.wr_edge = 1'b1;
                        edge_addr   = ecount_ff[EAW-1:0];
                        ecount_in   = ecount_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ACT_RUN: begin
                     n_in    = vcount_n;
                     bank_in = 1'b0;
                     k_in    = '0;
                     m_in    = '0;
                     if (ecount_ff == '0 || vcount_ff == '0) begin
                        state_in = S_EMIT_CHK;
                     end else begin
                        state_in = S_EDGE_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_EDGE_RD: begin
            cmd.rd_edge = 1'b1;
            cmd.rd_vert = 1'b1;
            rd_addr     = n_last[AW-1:0];
            m_in        = '0;
            i_in        = '0;
            state_in    = S_PREV_MUL;
         end
         S_PREV_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_PREV_SIDE;
         end
         S_PREV_SIDE: begin
            cmd.side_prev = 1'b1;
            state_in      = S_CUR_RD;
         end
         S_CUR_RD: begin
            cmd.rd_vert = 1'b1;
            rd_addr     = i_ff[AW-1:0];
            state_in    = S_CUR_MUL;
         end
         S_CUR_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CUR_SIDE;
         end
         S_CUR_SIDE: begin
            cmd.side_cur = 1'b1;
            state_in     = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.cur_in != status.prev_in) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (status.cur_in) begin
               state_in = S_PUSH_CUR;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_DIV_FIN;
            end
         end
         S_DIV_FIN: begin
            cmd.div_fin = 1'b1;
            state_in    = S_PUSH_X;
         end
         S_PUSH_X: begin
            cmd.wr_src = WR_CROSS;
            if (m_ff < NW'(WORK_DEPTH)) begin
               cmd.wr_vert = 1'b1;
               m_in        = m_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            state_in = status.cur_in ? S_PUSH_CUR : S_NEXT;
         end
         S_PUSH_CUR: begin
            cmd.wr_src = WR_CUR;
            if (m_ff < NW'(WORK_DEPTH)) begin
               cmd.wr_vert = 1'b1;
               m_in        = m_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            cmd.shift_prev = 1'b1;
            i_in           = i_next;
            state_in       = (i_next == n_ff) ? S_PASS_END : S_CUR_RD;
         end
         S_PASS_END: begin
            n_in    = m_ff;
            bank_in = ~bank_ff;
            k_in    = k_next;
            if (k_next == ecount_ff || m_ff == '0) begin
               state_in = S_EMIT_CHK;
            end else begin
               state_in = S_EDGE_RD;
            end
         end
         S_EMIT_CHK: begin
            j_in = '0;
            if (n_ff == '0) begin
               cmd.out_load  = 1'b1;
               cmd.out_empty = 1'b1;
               cmd.out_last  = 1'b1;
               last_in       = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_EMIT_HOLD;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            cmd.rd_vert = 1'b1;
            rd_addr     = j_ff[AW-1:0];
            state_in    = S_EMIT_LOAD;
         end
         S_EMIT_LOAD: begin
            cmd.out_load = 1'b1;
            cmd.out_last = (j_next == n_ff);
            last_in      = (j_next == n_ff);
            rsp_valid_in = 1'b1;
            state_in     = S_EMIT_HOLD;
         end
         S_EMIT_HOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  vcount_in = '0;
                  ecount_in = '0;
                  ovf_in    = 1'b0;
                  state_in  = S_IDLE;
               end else begin
                  j_in     = j_next;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bank_ff      <= 1'b0;
         vcount_ff    <= '0;
         ecount_ff    <= '0;
         k_ff         <= '0;
         ovf_ff       <= 1'b0;
         n_ff         <= '0;
         m_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         vcount_ff    <= vcount_in;
         ecount_ff    <= ecount_in;
         k_ff         <= k_in;
         ovf_ff       <= ovf_in;
         n_ff         <= n_in;
         m_ff         <= m_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/polygon_clipper.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sutherland-Hodgman polygon clipper.
// Request channel (req_valid / req_stall): each transaction carries an action.
//   Load subject vertex and load clip edge are taken while idle and return nothing;
//   a load beyond capacity is dropped and raises the overflow flag.
//   A run transaction clips the stored subject against every stored edge in
//   load order and then streams the resulting polygon on the response channel.
// Response channel (rsp_valid / rsp_stall): one transaction per output vertex,
//   rsp_last_vertex on the final one; an empty result gives a single
//   transaction with rsp_empty_result and rsp_last_vertex set and zero coords.
// Sequence: each pass has setup and wrap-up states, read, multiply, side,
//   decide and next steps per input vertex, a write per kept vertex, and a
//   division per side crossing (the x and y restoring dividers retire one
//   quotient bit a cycle). Each output vertex: buffer read, load, handoff.
// req_stall stays high from the run transaction until the last response is
//   taken; a stalled response holds its register. After the last response the
//   loaded vertices, edges and overflow flag are cleared.
// Reset (synchronous) clears counts and control; buffer contents stay undefined.

module polygon_clipper import pclip_pkg::*; #(
   parameter int unsigned MAX_SUBJECT_VERTS = DEF_MAX_SUBJECT_VERTS,
   parameter int unsigned MAX_CLIP_EDGES    = DEF_MAX_CLIP_EDGES,
   parameter int unsigned WORK_DEPTH        = DEF_WORK_DEPTH,
   parameter int unsigned COORD_BITS        = DEF_COORD_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_action,
   input  wire logic signed [COORD_BITS-1:0] req_vert_x,
   input  wire logic signed [COORD_BITS-1:0] req_vert_y,
   input  wire logic signed [COORD_BITS-1:0] req_edge_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_edge_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_edge_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_edge_end_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0]      rsp_out_x,
   output logic signed [COORD_BITS-1:0]      rsp_out_y,
   output logic                              rsp_last_vertex,
   output logic                              rsp_empty_result,
   output logic                              rsp_overflow
);

   // buffer and edge store address widths
   localparam int unsigned AW  = $clog2(WORK_DEPTH);
   localparam int unsigned EAW = (MAX_CLIP_EDGES > 1) ? $clog2(MAX_CLIP_EDGES) : 1;

   cmd_type        cmd;
   status_type     status;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [EAW-1:0] edge_addr;

   // sequencer: counts, pass loop, output handshake
   pclip_ctrl #(
      .MAX_SUBJECT_VERTS (MAX_SUBJECT_VERTS),
      .MAX_CLIP_EDGES    (MAX_CLIP_EDGES),
      .WORK_DEPTH        (WORK_DEPTH),
      .AW                (AW),
      .EAW               (EAW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .edge_addr  (edge_addr),
      .status     (status)
   );

   // storage, side test, crossing divider, output register
   pclip_datapath #(
      .WORK_DEPTH     (WORK_DEPTH),
      .MAX_CLIP_EDGES (MAX_CLIP_EDGES),
      .COORD_BITS     (COORD_BITS),
      .AW             (AW),
      .EAW            (EAW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .edge_addr        (edge_addr),
      .req_vert_x       (req_vert_x),
      .req_vert_y       (req_vert_y),
      .req_edge_start_x (req_edge_start_x),
      .req_edge_start_y (req_edge_start_y),
      .req_edge_end_x   (req_edge_end_x),
      .req_edge_end_y   (req_edge_end_y),
      .status           (status),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_last_vertex  (rsp_last_vertex),
      .rsp_empty_result (rsp_empty_result),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

`default_nettype wire

/* rtl/pclip_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pclip_checker import pclip_pkg::*; #(
   parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic [1:0]            req_action,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [COORD_BITS-1:0] rsp_out_x,
   input wire logic [COORD_BITS-1:0] rsp_out_y,
   input wire logic                  rsp_last_vertex,
   input wire logic                  rsp_empty_result
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
                                 && $stable(rsp_last_vertex))
      else $error("stalled response changed");

   // no request is taken while a response is pending
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request port open while response pending");

   // an empty result is a single zero vertex marked last
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_result |-> rsp_last_vertex && rsp_out_x == '0
                                        && rsp_out_y == '0)
      else $error("malformed empty result");

   // a run transaction makes the block busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_RUN |=> req_stall)
      else $error("run did not start");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind polygon_clipper pclip_checker #(.COORD_BITS(COORD_BITS)) u_pclip_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_action       (req_action),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_x        (rsp_out_x),
   .rsp_out_y        (rsp_out_y),
   .rsp_last_vertex  (rsp_last_vertex),
   .rsp_empty_result (rsp_empty_result)
);

`default_nettype wire
